### sv/mrs_pkg.sv
// Shared types, codes and the CRC-16/MODBUS step for the Modbus RTU register slave.
// No dependencies; every other file of the block imports this package.
package mrs_pkg;

  // Function codes that the slave serves.
  localparam logic [7:0] FC_READ  = 8'h03;
  localparam logic [7:0] FC_WRITE = 8'h06;

  // Exception codes and the bit that marks an exception function code.
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;
  localparam logic [7:0] EXC_FLAG             = 8'h80;

  // Broadcast address and quantity limits of a read.
  localparam logic [7:0]  ADDR_BROADCAST = 8'hFF;
  localparam logic [15:0] READ_QTY_MIN   = 16'h0001;
  localparam logic [15:0] READ_QTY_MAX   = 16'h007D;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Reply kind carried with each reply byte.
  localparam logic [1:0] KIND_NORMAL    = 2'd0;
  localparam logic [1:0] KIND_ECHO      = 2'd1;
  localparam logic [1:0] KIND_EXCEPTION = 2'd2;

  // Work handed from the front end to the back end.
  // For a local write, addr_field holds the index and data_field the value.
  typedef struct packed {
    logic        is_local;
    logic        bcast;
    logic [7:0]  fcode;
    logic [15:0] addr_field;
    logic [15:0] data_field;
  } cmd_t;

  // Reply being streamed by the back end.
  typedef enum logic [1:0] {
    MODE_READ,
    MODE_ECHO,
    MODE_EXC
  } reply_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } back_state_t;

  // One byte into a reflected CRC-16 (polynomial 0xA001).
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/mrs_cmd_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on mrs_pkg for cmd_t.
module mrs_cmd_queue
  import mrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = entries[rd_ptr];

  // Storage: payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### sv/mrs_front.sv
// Front end: takes received bytes and local writes, tracks the frame, checks
// address and CRC, and queues a request per accepted frame or local write.
// Depends on mrs_pkg.
module mrs_front
  import mrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       take,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  input  logic [3:0] local_index,
  input  logic [15:0] local_value,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0]  slave_addr;
  logic [7:0]  header [6];
  logic [7:0]  byte_count;
  logic [15:0] crc;
  logic [7:0]  held0;
  logic [7:0]  held1;

  logic [15:0] crc_next;
  logic [7:0]  count_next;
  logic [7:0]  pdu_len;
  logic [7:0]  hdr [6];
  logic        feed;
  logic        frame_ok;
  logic        is_byte;
  logic        at_end;

  assign is_byte = take && !operation;
  assign at_end  = is_byte && frame_end;
  assign feed    = (byte_count >= 8'd2);

  // Frame state after the current byte.
  always_comb begin
    crc_next   = feed ? crc_feed(crc, held0) : crc;
    count_next = (byte_count == 8'hFF) ? byte_count : byte_count + 8'd1;
    pdu_len    = count_next - 8'd2;
    for (int i = 0; i < 6; i++) begin
      if (8'(i) >= pdu_len || count_next < 8'd4) begin
        hdr[i] = 8'h00;
      end else if (feed && byte_count - 8'd2 == 8'(i)) begin
        hdr[i] = held0;
      end else begin
        hdr[i] = header[i];
      end
    end
    frame_ok = (count_next >= 8'd4)
            && (hdr[0] == ADDR_BROADCAST || hdr[0] == slave_addr)
            && (held1 == crc_next[7:0]) && (rx_byte == crc_next[15:8]);
  end

  // Request to the back end.
  always_comb begin
    push_cmd.is_local   = operation;
    push_cmd.bcast      = (hdr[0] == ADDR_BROADCAST);
    push_cmd.fcode      = hdr[1];
    push_cmd.addr_field = operation ? {12'h000, local_index} : {hdr[2], hdr[3]};
    push_cmd.data_field = operation ? local_value : {hdr[4], hdr[5]};
    push = take && (operation || (frame_end && frame_ok));
  end

  // Header capture: no reset, each entry is written before it is used.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (is_byte && feed && byte_count - 8'd2 == 8'(i)) begin
        header[i] <= held0;
      end
    end
  end

  // Frame tracking and own address.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= 8'd1;
      byte_count <= 8'd0;
      crc        <= CRC_INIT;
      held0      <= 8'd0;
      held1      <= 8'd0;
    end else begin
      if (cfg_wen) begin
        slave_addr <= cfg_wdata;
      end
      if (at_end) begin
        byte_count <= 8'd0;
        crc        <= CRC_INIT;
        held0      <= 8'd0;
        held1      <= 8'd0;
      end else if (is_byte) begin
        byte_count <= count_next;
        crc        <= crc_next;
        held0      <= held1;
        held1      <= rx_byte;
      end
    end
  end

endmodule

### sv/mrs_back.sv
// Back end: executes queued requests on the register bank and streams reply bytes
// through an output register. Depends on mrs_pkg.
module mrs_back
  import mrs_pkg::*;
#(
  parameter int REGISTER_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_kind
);

  localparam int IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [16:0] RC17 = 17'(REGISTER_COUNT);

  logic [15:0] bank [REGISTER_COUNT];

  back_state_t state, state_next;
  reply_mode_t mode, mode_next;
  logic [7:0]  p, p_next;
  logic [7:0]  len, len_next;
  logic [7:0]  fcode, fcode_next;
  logic [7:0]  code, code_next;
  logic [15:0] f1, f1_next;
  logic [15:0] f2, f2_next;

  logic        in_range;
  logic        do_write;
  logic        load;
  logic [7:0]  byte_val;
  logic        byte_last;
  logic [1:0]  byte_kind;
  logic [7:0]  off;
  logic [4:0]  raddr;
  logic [15:0] rword;

  assign in_range = ({1'b0, head_cmd.addr_field} < RC17);

  // Reply byte at position p.
  always_comb begin
    off       = (p - 8'd2) >> 1;
    raddr     = f1[4:0] + off[4:0];
    rword     = bank[raddr[IW-1:0]];
    byte_last = (p == len - 8'd1);
    byte_val  = 8'h00;
    byte_kind = KIND_NORMAL;
    unique case (mode)
      MODE_READ: begin
        byte_kind = KIND_NORMAL;
        if (p == 8'd0) begin
          byte_val = FC_READ;
        end else if (p == 8'd1) begin
          byte_val = {f2[6:0], 1'b0};
        end else begin
          byte_val = p[0] ? rword[7:0] : rword[15:8];
        end
      end
      MODE_ECHO: begin
        byte_kind = KIND_ECHO;
        unique case (p[2:0])
          3'd0:    byte_val = fcode;
          3'd1:    byte_val = f1[15:8];
          3'd2:    byte_val = f1[7:0];
          3'd3:    byte_val = f2[15:8];
          default: byte_val = f2[7:0];
        endcase
      end
      default: begin
        byte_kind = KIND_EXCEPTION;
        byte_val  = p[0] ? code : fcode;
      end
    endcase
  end

  // Sequencer: classify a request, then stream its reply unless it is local or broadcast.
  always_comb begin
    state_next = state;
    mode_next  = mode;
    p_next     = p;
    len_next   = len;
    fcode_next = fcode;
    code_next  = code;
    f1_next    = f1;
    f2_next    = f2;
    pop        = 1'b0;
    do_write   = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          p_next     = 8'd0;
          f1_next    = head_cmd.addr_field;
          f2_next    = head_cmd.data_field;
          fcode_next = head_cmd.fcode;
          if (head_cmd.is_local) begin
            do_write = in_range;
          end else begin
            priority if (head_cmd.fcode == FC_READ) begin
              if (head_cmd.data_field < READ_QTY_MIN || head_cmd.data_field > READ_QTY_MAX) begin
                mode_next  = MODE_EXC;
                fcode_next = FC_READ | EXC_FLAG;
                code_next  = EXC_ILLEGAL_VALUE;
                len_next   = 8'd2;
              end else if ({1'b0, head_cmd.addr_field} + {1'b0, head_cmd.data_field} > RC17) begin
                mode_next  = MODE_EXC;
                fcode_next = FC_READ | EXC_FLAG;
                code_next  = EXC_ILLEGAL_ADDRESS;
                len_next   = 8'd2;
              end else begin
                mode_next = MODE_READ;
                len_next  = {head_cmd.data_field[6:0], 1'b0} + 8'd2;
              end
            end else if (head_cmd.fcode == FC_WRITE) begin
              if (in_range) begin
                do_write  = 1'b1;
                mode_next = MODE_ECHO;
                len_next  = 8'd5;
              end else begin
                mode_next  = MODE_EXC;
                fcode_next = FC_WRITE | EXC_FLAG;
                code_next  = EXC_ILLEGAL_ADDRESS;
                len_next   = 8'd2;
              end
            end else begin
              mode_next  = MODE_EXC;
              fcode_next = head_cmd.fcode + EXC_FLAG;
              code_next  = EXC_ILLEGAL_FUNCTION;
              len_next   = 8'd2;
            end
            if (!head_cmd.bcast) begin
              state_next = ST_SEND;
            end
          end
        end
      end
      default: begin
        if (!out_valid || out_ready) begin
          load   = 1'b1;
          p_next = p + 8'd1;
          if (byte_last) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  // Register bank: written by local writes and function 6.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        bank[i] <= 16'h0000;
      end
    end else if (do_write) begin
      bank[head_cmd.addr_field[IW-1:0]] <= head_cmd.data_field;
    end
  end

  // Sequencer registers; payload fields need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    mode  <= mode_next;
    p     <= p_next;
    len   <= len_next;
    fcode <= fcode_next;
    code  <= code_next;
    f1    <= f1_next;
    f2    <= f2_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_byte <= byte_val;
      out_last <= byte_last;
      out_kind <= byte_kind;
    end
  end

endmodule

### sv/modbus_rtu_register_slave_unit.sv
// Modbus RTU register slave: top level joining front end, request queue and back end.
// Depends on mrs_pkg, mrs_front, mrs_cmd_queue and mrs_back.
//
// Usage: the slave channel carries received frame bytes (tuser = 0, tlast on the
// final byte, CRC included) or local register writes from the application
// (tuser = 1). The master channel carries reply PDU bytes, function code first,
// with tlast on the final byte and the reply kind in tuser.
// The front end takes one byte or local write per cycle while the two-entry request queue has
// room; address and CRC are checked as the last byte arrives, so a frame's reply
// request is queued in the cycle after its final byte.
// The back end takes each queued request in its idle state, then sends one reply
// byte per cycle through its output register while the receiver takes them; it
// starts the next request only after the final byte of a reply is loaded.
// A stalled receiver holds the output register; the queue then fills and tready
// drops until the back end moves on, with nothing lost.
// Reset clears the register bank, the frame tracking and the queue, and sets
// the own address to 1. The own address is written through cfg_wen / cfg_wdata.
module modbus_rtu_register_slave_unit
  import mrs_pkg::*;
#(
  parameter int REGISTER_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [11:8] local_index, [27:12] local_value, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // [1:0] reply_kind
  output logic [1:0]  m_axis_tuser
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  assign s_axis_tready = !q_full;

  // Request intake and frame checking.
  mrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .take        (s_axis_tvalid && s_axis_tready),
    .operation   (s_axis_tuser),
    .rx_byte     (s_axis_tdata[7:0]),
    .frame_end   (s_axis_tlast),
    .local_index (s_axis_tdata[11:8]),
    .local_value (s_axis_tdata[27:12]),
    .push        (q_push),
    .push_cmd    (q_push_cmd)
  );

  // Queue between the two halves.
  mrs_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // Execution and reply streaming.
  mrs_back #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_kind   (m_axis_tuser)
  );

endmodule
